// ----- rtl/fpa_pkg.sv -----
// Shared constants and codes of the flash page allocator.
package fpa_pkg;

    // Geometry
    localparam int BANK_COUNT      = 8;
    localparam int BLOCKS_PER_BANK = 4096;
    localparam int PAGES_PER_BLOCK = 128;
    localparam int STREAM_COUNT    = 2 * BANK_COUNT;

    // Field widths
    localparam int MODE_W = 2;
    localparam int BANK_W = 3;
    localparam int BLK_W  = 12;
    localparam int PAGE_W = 19;
    localparam int FREE_W = 12;
    localparam int STAT_W = 2;
    localparam int NB_W   = BLK_W + 1;
    localparam int BADC_W = 13;
    localparam int FREE_MAX = 4095;

    // Stream bus widths
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = MODE_W + 1;
    localparam int OUT_TDATA_W = 32;

    // Bad-block bitmap organisation: one memory word holds flags of MAP_WORD_W blocks
    localparam int MAP_WORD_W     = 32;
    localparam int WSEL_W         = $clog2(MAP_WORD_W);
    localparam int WORDS_PER_BANK = (BLOCKS_PER_BANK + MAP_WORD_W - 1) / MAP_WORD_W;
    localparam int WIX_W          = $clog2(WORDS_PER_BANK);
    localparam int BANK_IW        = $clog2(BANK_COUNT);
    localparam int MAP_AW         = BANK_IW + WIX_W;
    localparam int MAP_DEPTH      = 1 << MAP_AW;

    // Item kinds
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MARK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INIT  = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_GOOD = 2'd2;

endpackage

// ----- rtl/fpa_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module fpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/flash_page_allocator_bad_block_skip.sv -----
// Flash page allocator: per-bank user/system page streams with bad-block skipping.
// Steps: an item is decoded in S_EXEC, then a block claim scans the bitmap in S_SCAN word by word
//   (32 blocks per word, up to 128 words per bank) and a mark-bad updates it in S_MARK; S_DONE
//   hands the result to the output register. One item in flight: the next is taken once the
//   last result sits in the output register, later while the receiver holds back the output.
// Reset: synchronous, active low; then all 1024 bitmap words are cleared with tready held low.
module flash_page_allocator_bad_block_skip
    import fpa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // bank[2:0], block_index[14:3], pad
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // mode[1:0], stream_select[2]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // page_number[18:0], free_blocks[30:19], pad
    output logic [STAT_W-1:0]      m_axis_tuser    // status[1:0]
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_MARK,
        S_DONE
    } t_state;

    // free count after an init: blocks minus bad minus reserved block 0, saturated
    function automatic logic [FREE_W-1:0] init_free(input logic [BADC_W-1:0] bad);
        int used;
        int f;
        used = int'(bad) + 1;
        f    = 0;
        if (used < BLOCKS_PER_BANK) begin
            f = BLOCKS_PER_BANK - used;
        end
        if (f > FREE_MAX) begin
            f = FREE_MAX;
        end
        return FREE_W'(f);
    endfunction

    // Control and item registers
    t_state              r_state, n_state;
    logic [MAP_AW-1:0]   r_clr, n_clr;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [BANK_W-1:0]   r_bank, n_bank;
    logic                r_sel, n_sel;
    logic [BLK_W-1:0]    r_blk, n_blk;
    logic [NB_W-1:0]     r_nb, n_nb;

    // Per-bank and per-stream state
    logic [PAGE_W-1:0]   r_spage [STREAM_COUNT];
    logic [PAGE_W-1:0]   n_spage [STREAM_COUNT];
    logic [NB_W-1:0]     r_next  [BANK_COUNT];
    logic [NB_W-1:0]     n_next  [BANK_COUNT];
    logic [FREE_W-1:0]   r_free  [BANK_COUNT];
    logic [FREE_W-1:0]   n_free  [BANK_COUNT];
    logic [BADC_W-1:0]   r_bad   [BANK_COUNT];
    logic [BADC_W-1:0]   n_bad   [BANK_COUNT];

    // Result held until the output slot frees, and the output slot itself
    logic [PAGE_W-1:0]   r_res_page, n_res_page;
    logic [FREE_W-1:0]   r_res_free, n_res_free;
    logic [STAT_W-1:0]   r_res_status, n_res_status;
    logic                r_out_valid, n_out_valid;
    logic [PAGE_W-1:0]   r_out_page, n_out_page;
    logic [FREE_W-1:0]   r_out_free, n_out_free;
    logic [STAT_W-1:0]   r_out_status, n_out_status;

    // Bitmap RAM ports
    logic                  ram_we;
    logic [MAP_AW-1:0]     ram_waddr;
    logic [MAP_WORD_W-1:0] ram_wdata;
    logic [MAP_AW-1:0]     ram_raddr;
    logic [MAP_WORD_W-1:0] ram_rdata;

    // Decoded views of the current item
    logic                    bank_ok;
    logic [BANK_IW-1:0]      bix;
    logic [BANK_IW:0]        sidx;
    logic [FREE_W-1:0]       cur_free;
    logic [PAGE_W-1:0]       cur_page;
    logic [NB_W-1:0]         cur_nb;
    logic [MAP_WORD_W-1:0]   masked;
    logic [WSEL_W-1:0]       pos;
    logic                    found_any;
    logic [WIX_W+WSEL_W-1:0] found_blk;
    logic [NB_W-1:0]         nxt_nb;
    logic [PAGE_W-1:0]       claim_page;
    logic                    mark_bit;

    fpa_ram #(
        .WIDTH (MAP_WORD_W),
        .DEPTH (MAP_DEPTH)
    ) u_bad_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Item decode
    always_comb begin
        bank_ok  = 32'(r_bank) < BANK_COUNT;
        bix      = r_bank[BANK_IW-1:0];
        sidx     = {bix, r_sel};
        cur_free = bank_ok ? r_free[bix] : '0;
        cur_page = r_spage[sidx];
        cur_nb   = r_next[bix];
        mark_bit = ram_rdata[r_blk[WSEL_W-1:0]];
    end

    // First good block in the bitmap word at or above the scan pointer
    always_comb begin
        masked    = ~ram_rdata & ({MAP_WORD_W{1'b1}} << r_nb[WSEL_W-1:0]);
        found_any = |masked;
        pos       = '0;
        for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
            if (masked[i]) begin
                pos = WSEL_W'(i);
            end
        end
        found_blk  = {r_nb[WSEL_W+WIX_W-1:WSEL_W], pos};
        nxt_nb     = (NB_W'(r_nb[WSEL_W+WIX_W-1:WSEL_W]) + NB_W'(1)) << WSEL_W;
        claim_page = PAGE_W'(32'(found_blk) * PAGES_PER_BLOCK);
    end

    // Next-state logic
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_mode       = r_mode;
        n_bank       = r_bank;
        n_sel        = r_sel;
        n_blk        = r_blk;
        n_nb         = r_nb;
        n_spage      = r_spage;
        n_next       = r_next;
        n_free       = r_free;
        n_bad        = r_bad;
        n_res_page   = r_res_page;
        n_res_free   = r_res_free;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_page   = r_out_page;
        n_out_free   = r_out_free;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = r_clr;
        ram_wdata    = '0;
        ram_raddr    = {bix, r_nb[WSEL_W+WIX_W-1:WSEL_W]};

        unique case (r_state)
            // zero the bitmap one word a cycle
            S_CLEAR: begin
                ram_we = 1'b1;
                n_clr  = r_clr + MAP_AW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mode  = s_axis_tuser[MODE_W-1:0];
                    n_sel   = s_axis_tuser[MODE_W];
                    n_bank  = s_axis_tdata[BANK_W-1:0];
                    n_blk   = s_axis_tdata[BANK_W+BLK_W-1:BANK_W];
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_res_page   = '0;
                n_res_free   = cur_free;
                n_res_status = ST_OK;
                n_state      = S_DONE;
                case (r_mode)
                    MODE_ALLOC: begin
                        if (!bank_ok || cur_free == '0) begin
                            n_res_status = ST_NO_FREE;
                        end else if (cur_page % PAGES_PER_BLOCK != 0) begin
                            // still inside the stream's block
                            n_spage[sidx] = cur_page + PAGE_W'(1);
                            n_res_page    = cur_page;
                        end else if (32'(cur_nb) >= BLOCKS_PER_BANK) begin
                            n_res_status = ST_NO_GOOD;
                        end else begin
                            // block boundary: start the bad-block scan
                            n_nb      = cur_nb;
                            ram_raddr = {bix, cur_nb[WSEL_W+WIX_W-1:WSEL_W]};
                            n_state   = S_SCAN;
                        end
                    end
                    MODE_MARK: begin
                        if (bank_ok && 32'(r_blk) < BLOCKS_PER_BANK) begin
                            ram_raddr = {bix, r_blk[WSEL_W+WIX_W-1:WSEL_W]};
                            n_state   = S_MARK;
                        end
                    end
                    MODE_INIT: begin
                        for (int b = 0; b < BANK_COUNT; b++) begin
                            n_free[b]      = init_free(r_bad[b]);
                            n_next[b]      = NB_W'(1);
                            n_spage[2*b]   = '0;
                            n_spage[2*b+1] = '0;
                        end
                        n_res_free = bank_ok ? init_free(r_bad[bix]) : '0;
                    end
                    default: begin
                    end
                endcase
            end

            // one bitmap word per cycle
            S_SCAN: begin
                n_res_page   = '0;
                n_res_free   = cur_free;
                n_res_status = ST_OK;
                if (found_any && 32'(found_blk) < BLOCKS_PER_BANK) begin
                    n_spage[sidx] = claim_page + PAGE_W'(1);
                    n_next[bix]   = NB_W'(found_blk) + NB_W'(1);
                    n_free[bix]   = cur_free - FREE_W'(1);
                    n_res_page    = claim_page;
                    n_res_free    = cur_free - FREE_W'(1);
                    n_state       = S_DONE;
                end else if (!found_any && 32'(nxt_nb) < BLOCKS_PER_BANK) begin
                    n_nb      = nxt_nb;
                    ram_raddr = {bix, nxt_nb[WSEL_W+WIX_W-1:WSEL_W]};
                end else begin
                    n_res_status = ST_NO_GOOD;
                    n_state      = S_DONE;
                end
            end

            // read-modify-write of the bitmap word
            S_MARK: begin
                ram_waddr = {bix, r_blk[WSEL_W+WIX_W-1:WSEL_W]};
                ram_wdata = ram_rdata | (MAP_WORD_W'(1) << r_blk[WSEL_W-1:0]);
                if (!mark_bit) begin
                    ram_we     = 1'b1;
                    n_bad[bix] = r_bad[bix] + BADC_W'(1);
                end
                n_res_page   = '0;
                n_res_free   = cur_free;
                n_res_status = ST_OK;
                n_state      = S_DONE;
            end

            // hand the result to the output slot once it is free
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_page   = r_res_page;
                    n_out_free   = r_res_free;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int b = 0; b < BANK_COUNT; b++) begin
                r_next[b] <= NB_W'(1);
                r_free[b] <= '0;
                r_bad[b]  <= '0;
            end
            for (int s = 0; s < STREAM_COUNT; s++) begin
                r_spage[s] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_next      <= n_next;
            r_free      <= n_free;
            r_bad       <= n_bad;
            r_spage     <= n_spage;
        end
        r_mode       <= n_mode;
        r_bank       <= n_bank;
        r_sel        <= n_sel;
        r_blk        <= n_blk;
        r_nb         <= n_nb;
        r_res_page   <= n_res_page;
        r_res_free   <= n_res_free;
        r_res_status <= n_res_status;
        r_out_page   <= n_out_page;
        r_out_free   <= n_out_free;
        r_out_status <= n_out_status;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-PAGE_W-FREE_W){1'b0}}, r_out_free, r_out_page};
    assign m_axis_tuser  = r_out_status;

    // A failed allocation never carries a page number
    a_fail_no_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata[PAGE_W-1:0] == '0))
        else $error("failed allocation carries a page number");

    // The bitmap is only written by the clearing pass or a mark-bad update
    a_ram_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || r_state == S_MARK))
        else $error("bitmap written outside clear or mark");

    // A pending result waits while the output slot is still occupied
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !m_axis_tready) |=> (r_state == S_DONE))
        else $error("result overwrote an undelivered item");

    // No item is taken during the clearing pass
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("item accepted during bitmap clear");

endmodule

// ----- tb/sv/tb_flash_page_allocator_bad_block_skip.sv -----
// Self-checking testbench of the flash page allocator.
module tb_flash_page_allocator_bad_block_skip;
    import fpa_pkg::*;

    // Unused item kind: no operation, reports the bank's free count
    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

    localparam int ITEMS_PER_PHASE = 350;
    localparam int SWEEP_BLOCKS    = 575;
    localparam int STALL_LIMIT     = 5000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int REPORT_CAP      = 200;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [FREE_W-1:0] free_blocks;
        logic [STAT_W-1:0] status;
    } t_alloc_result;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BANK_W-1:0] bank;
        logic              sel;
        logic [BLK_W-1:0]  blk;
        logic              typed;
        t_alloc_result     want;
    } t_directed_item;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // bank[2:0], block_index[14:3], pad
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;   // mode[1:0], stream_select[2]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // page_number[18:0], free_blocks[30:19], pad
    logic [STAT_W-1:0]      m_axis_tuser;          // status[1:0]

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned fail_count  = 0;
    int unsigned stall_count = 0;

    // Expected results, oldest first
    t_alloc_result pending_results [$];

    // Allocator state as predicted
    int unsigned stream_page [STREAM_COUNT]               = '{default: 0};
    int unsigned claim_ptr   [BANK_COUNT]                 = '{default: 1};
    int unsigned free_left   [BANK_COUNT]                 = '{default: 0};
    int unsigned bad_total   [BANK_COUNT]                 = '{default: 0};
    bit          bad_flag    [BANK_COUNT][BLOCKS_PER_BANK];

    // Directed items: fixed answers only where they are obvious
    t_directed_item directed_items [20] = '{
        // before any init every bank has no free blocks
        '{MODE_ALLOC, 3'd0, 1'b0, 12'd0,    1'b1, '{19'd0, 12'd0, ST_NO_FREE}},
        '{MODE_ALLOC, 3'd7, 1'b1, 12'hFFF,  1'b1, '{19'd0, 12'd0, ST_NO_FREE}},
        '{MODE_NOP,   3'd3, 1'b1, 12'hFFF,  1'b1, '{19'd0, 12'd0, ST_OK}},
        '{MODE_MARK,  3'd0, 1'b0, 12'd2,    1'b1, '{19'd0, 12'd0, ST_OK}},
        // same block again: bad count must not move
        '{MODE_MARK,  3'd0, 1'b1, 12'd2,    1'b1, '{19'd0, 12'd0, ST_OK}},
        '{MODE_MARK,  3'd0, 1'b0, 12'd0,    1'b1, '{19'd0, 12'd0, ST_OK}},
        '{MODE_MARK,  3'd7, 1'b0, 12'hFFF,  1'b1, '{19'd0, 12'd0, ST_OK}},
        '{MODE_MARK,  3'd0, 1'b0, 12'd3,    1'b1, '{19'd0, 12'd0, ST_OK}},
        // bank 5 has no bad blocks: full free count
        '{MODE_INIT,  3'd5, 1'b0, 12'd0,    1'b1, '{19'd0, 12'd4095, ST_OK}},
        '{MODE_ALLOC, 3'd0, 1'b0, 12'd0,    1'b0, '0},
        '{MODE_ALLOC, 3'd0, 1'b1, 12'd0,    1'b0, '0},
        '{MODE_ALLOC, 3'd0, 1'b0, 12'hFFF,  1'b0, '0},
        '{MODE_ALLOC, 3'd7, 1'b0, 12'd0,    1'b0, '0},
        '{MODE_ALLOC, 3'd7, 1'b1, 12'd0,    1'b0, '0},
        '{MODE_MARK,  3'd1, 1'b0, 12'h555,  1'b0, '0},
        '{MODE_MARK,  3'd6, 1'b1, 12'hAAA,  1'b0, '0},
        '{MODE_NOP,   3'd0, 1'b0, 12'h3C3,  1'b0, '0},
        '{MODE_INIT,  3'd2, 1'b1, 12'd0,    1'b0, '0},
        '{MODE_ALLOC, 3'd2, 1'b1, 12'd0,    1'b0, '0},
        '{MODE_ALLOC, 3'd4, 1'b0, 12'd0,    1'b0, '0}
    };

    flash_page_allocator_bad_block_skip dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Predicted answer to one item; updates the predicted state
    function automatic t_alloc_result predict_allocation(input logic [MODE_W-1:0] mode,
                                                         input logic [BANK_W-1:0] bank,
                                                         input logic              sel,
                                                         input logic [BLK_W-1:0]  blk);
        t_alloc_result r;
        int unsigned   sidx;
        int unsigned   page;
        int unsigned   nb;
        int unsigned   used;
        int unsigned   f;
        r = '0;
        case (mode)
            MODE_ALLOC: begin
                if (free_left[bank] == 0) begin
                    r.status = ST_NO_FREE;
                    return r;
                end
                sidx = bank * 2 + sel;
                page = stream_page[sidx];
                // block boundary: claim the next good block
                if (page % PAGES_PER_BLOCK == 0) begin
                    nb = claim_ptr[bank];
                    while (nb < BLOCKS_PER_BANK && bad_flag[bank][nb])
                        nb++;
                    if (nb >= BLOCKS_PER_BANK) begin
                        r.free_blocks = FREE_W'(free_left[bank]);
                        r.status      = ST_NO_GOOD;
                        return r;
                    end
                    page            = nb * PAGES_PER_BLOCK;
                    claim_ptr[bank] = nb + 1;
                    free_left[bank] = free_left[bank] - 1;
                end
                stream_page[sidx] = page + 1;
                r.page            = PAGE_W'(page);
                r.free_blocks     = FREE_W'(free_left[bank]);
                r.status          = ST_OK;
                return r;
            end
            MODE_MARK: begin
                if (!bad_flag[bank][blk]) begin
                    bad_flag[bank][blk] = 1'b1;
                    bad_total[bank]     = bad_total[bank] + 1;
                end
            end
            MODE_INIT: begin
                for (int b = 0; b < BANK_COUNT; b++) begin
                    used = bad_total[b] + 1;
                    f    = (used < BLOCKS_PER_BANK) ? BLOCKS_PER_BANK - used : 0;
                    if (f > FREE_MAX)
                        f = FREE_MAX;
                    stream_page[b * 2]     = 0;
                    stream_page[b * 2 + 1] = 0;
                    free_left[b]           = f;
                    claim_ptr[b]           = 1;
                end
            end
            default: ;
        endcase
        r.free_blocks = FREE_W'(free_left[bank]);
        return r;
    endfunction

    // Offer one item, wait for acceptance, queue its expected result
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [BANK_W-1:0] bank,
                             input logic sel, input logic [BLK_W-1:0] blk,
                             input logic typed, input t_alloc_result want);
        t_alloc_result predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, blk, bank};
        s_axis_tuser  <= {sel, mode};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        predicted = predict_allocation(mode, bank, sel, blk);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Random item, mostly allocations on a few hot streams so blocks fill and get claimed
    task automatic send_random_item();
        logic [MODE_W-1:0] mode;
        logic [BANK_W-1:0] bank;
        logic              sel;
        logic [BLK_W-1:0]  blk;
        int unsigned       roll;
        int unsigned       pick;
        roll = $urandom_range(999);
        if (roll < 720)
            mode = MODE_ALLOC;
        else if (roll < 950)
            mode = MODE_MARK;
        else if (roll < 955)
            mode = MODE_INIT;
        else
            mode = MODE_NOP;
        pick = $urandom_range(99);
        if (pick < 55)
            bank = 3'd0;
        else if (pick < 70)
            bank = 3'd1;
        else
            bank = BANK_W'($urandom_range(BANK_COUNT - 1));
        sel = (bank == 3'd0) ? ($urandom_range(99) < 80 ? 1'b0 : 1'b1) : 1'($urandom_range(1));
        blk = BLK_W'($urandom);
        // marks near the claim pointer make the scan skip
        if (mode == MODE_MARK && $urandom_range(1))
            blk = BLK_W'($urandom_range(48));
        send_item(mode, bank, sel, blk, 1'b0, '0);
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Result checker
    always @(posedge i_clk) begin : check_result
        t_alloc_result want;
        t_alloc_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[PAGE_W-1:0], m_axis_tdata[PAGE_W+FREE_W-1:PAGE_W], m_axis_tuser};
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $error("unexpected result: page_number %0d free_blocks %0d status %0d",
                           got.page, got.free_blocks, got.status);
            end else begin
                want = pending_results.pop_front();
                if (got.page !== want.page) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $error("page_number: expected %0d, actual %0d", want.page, got.page);
                end
                if (got.free_blocks !== want.free_blocks) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $error("free_blocks: expected %0d, actual %0d",
                               want.free_blocks, got.free_blocks);
                end
                if (got.status !== want.status) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                end
            end
        end
    end

    // Watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the first idling pattern
        tx_idle_pct = 32;
        rx_idle_pct = 73;
        foreach (directed_items[i])
            send_item(directed_items[i].mode, directed_items[i].bank, directed_items[i].sel,
                      directed_items[i].blk, directed_items[i].typed, directed_items[i].want);

        // random phases: receiver idles most, then sender idles most, then neither
        for (int p = 0; p < 3; p++) begin
            tx_idle_pct = (p == 0) ? 32 : (p == 1) ? 73 : 0;
            rx_idle_pct = (p == 0) ? 73 : (p == 1) ? 32 : 0;
            send_item(MODE_INIT, BANK_W'($urandom_range(BANK_COUNT - 1)), 1'b0, 12'd0, 1'b0, '0);
            repeat (ITEMS_PER_PHASE)
                send_random_item();
            // hold off until every result is back
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            wait_results_drained();
        end

        // bank 7: a long run of blocks goes bad after init, so the scan walks many words
        send_item(MODE_INIT, 3'd7, 1'b0, 12'd0, 1'b0, '0);
        for (int b = 1; b <= SWEEP_BLOCKS; b++)
            send_item(MODE_MARK, 3'd7, 1'(b), BLK_W'(b), 1'b0, '0);
        send_item(MODE_ALLOC, 3'd7, 1'b0, 12'd0, 1'b0, '0);
        send_item(MODE_ALLOC, 3'd7, 1'b1, 12'd0, 1'b0, '0);
        // block 0 bad as well, then init recounts the free blocks
        send_item(MODE_MARK, 3'd7, 1'b0, 12'd0, 1'b0, '0);
        send_item(MODE_INIT, 3'd7, 1'b0, 12'd0, 1'b0, '0);
        send_item(MODE_ALLOC, 3'd7, 1'b1, 12'd0, 1'b0, '0);
        send_item(MODE_ALLOC, 3'd0, 1'b0, 12'd0, 1'b0, '0);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/fpa_pkg.sv
rtl/fpa_ram.sv
rtl/flash_page_allocator_bad_block_skip.sv
tb/sv/tb_flash_page_allocator_bad_block_skip.sv
